// ===== hw/rtl/rtt_est_pkg.sv =====
// Package with shared types, codes and constants of the RTT estimator.
package rtt_est_pkg;

    localparam int unsigned SAMPLE_BITS_DEF = 32;
    localparam int unsigned SAMPLE_W_MAX    = 32;
    localparam int unsigned ERR_W           = 33;
    localparam int unsigned SRTT_W          = 36;
    localparam int unsigned RTTVAR_W        = 35;
    localparam int unsigned RTO_W           = 36;
    localparam int unsigned CNT_W           = 8;
    localparam int unsigned CFG_W           = 32;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned OP_W            = 2;

    localparam logic [CFG_W-1:0] MIN_RTO_RESET  = 32'd2000000;
    localparam logic [CFG_W-1:0] MAX_RTO_RESET  = 32'd60000000;
    localparam logic [CNT_W-1:0] MAX_RETX_RESET = 8'd3;
    localparam logic [CNT_W-1:0] CNT_SAT        = 8'hFF;

    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_NEW_PKT = 2'd1;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RTO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RTO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETX = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] min_rto;
        logic [CFG_W-1:0] max_rto;
        logic [CNT_W-1:0] max_retx;
    } t_cfg;

    typedef struct packed {
        logic [RTO_W-1:0] rto;
        logic             give_up;
    } t_result;

endpackage

// ===== hw/rtl/rtt_est_cfg.sv =====
// Configuration register bank of the RTT estimator.
module rtt_est_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rtt_est_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rtt_est_pkg::CFG_W-1:0]       i_cfg_wdata,
    output rtt_est_pkg::t_cfg                   o_cfg
);

    rtt_est_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_rto  <= rtt_est_pkg::MIN_RTO_RESET;
            r_cfg.max_rto  <= rtt_est_pkg::MAX_RTO_RESET;
            r_cfg.max_retx <= rtt_est_pkg::MAX_RETX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtt_est_pkg::REG_MIN_RTO: begin
                    r_cfg.min_rto <= i_cfg_wdata;
                end
                rtt_est_pkg::REG_MAX_RTO: begin
                    r_cfg.max_rto <= i_cfg_wdata;
                end
                rtt_est_pkg::REG_MAX_RETX: begin
                    r_cfg.max_retx <= i_cfg_wdata[rtt_est_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/rtt_est_core.sv =====
// Estimator state and the single-pass event datapath of the RTT estimator.
module rtt_est_core #(
    parameter int unsigned SAMPLE_BITS = rtt_est_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [rtt_est_pkg::OP_W-1:0]    i_op,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  rtt_est_pkg::t_cfg               i_cfg,
    output rtt_est_pkg::t_result            o_result
);

    localparam int unsigned ERR_W = rtt_est_pkg::ERR_W;

    logic [rtt_est_pkg::SRTT_W-1:0]   r_srtt;
    logic [rtt_est_pkg::RTTVAR_W-1:0] r_rttvar;
    logic [rtt_est_pkg::RTO_W-1:0]    r_rto;
    logic [rtt_est_pkg::CNT_W-1:0]    r_retx;

    logic [rtt_est_pkg::SRTT_W-1:0]   n_srtt;
    logic [rtt_est_pkg::RTTVAR_W-1:0] n_rttvar;
    logic [rtt_est_pkg::RTO_W-1:0]    n_rto;
    logic [rtt_est_pkg::CNT_W-1:0]    n_retx;
    logic                             w_give_up;

    logic [ERR_W-1:0]                 w_sample;
    logic [ERR_W-1:0]                 w_old_avg;
    logic [ERR_W-1:0]                 w_abs_err;
    logic [rtt_est_pkg::SRTT_W-1:0]   w_srtt_meas;
    logic [rtt_est_pkg::RTTVAR_W-1:0] w_rttvar_meas;
    logic [rtt_est_pkg::RTO_W-1:0]    w_rto_meas;
    logic [rtt_est_pkg::RTO_W:0]      w_rto_dbl;
    logic [rtt_est_pkg::RTO_W-1:0]    w_rto_clamp;
    logic [rtt_est_pkg::CNT_W-1:0]    w_retx_inc;

    assign w_sample  = {{(ERR_W - SAMPLE_BITS){1'b0}}, i_sample};
    assign w_old_avg = r_srtt[rtt_est_pkg::SRTT_W-1:3];
    assign w_abs_err = (w_sample >= w_old_avg) ? (w_sample - w_old_avg)
                                               : (w_old_avg - w_sample);

    assign w_srtt_meas = r_srtt - {3'b000, w_old_avg} + {3'b000, w_sample};
    assign w_rttvar_meas = r_rttvar - {2'b00, r_rttvar[rtt_est_pkg::RTTVAR_W-1:2]}
                         + {2'b00, w_abs_err};
    assign w_rto_meas = {3'b000, w_srtt_meas[rtt_est_pkg::SRTT_W-1:3]}
                      + {1'b0, w_rttvar_meas};

    // The lower clamp is tested first, so it wins when the limits cross.
    assign w_rto_dbl = {r_rto, 1'b0};
    always_comb begin
        if (w_rto_dbl < {5'd0, i_cfg.min_rto}) begin
            w_rto_clamp = {4'd0, i_cfg.min_rto};
        end else if (w_rto_dbl > {5'd0, i_cfg.max_rto}) begin
            w_rto_clamp = {4'd0, i_cfg.max_rto};
        end else begin
            w_rto_clamp = w_rto_dbl[rtt_est_pkg::RTO_W-1:0];
        end
    end

    assign w_retx_inc = (r_retx != rtt_est_pkg::CNT_SAT) ? (r_retx + 8'd1) : r_retx;

    always_comb begin
        n_srtt    = r_srtt;
        n_rttvar  = r_rttvar;
        n_rto     = r_rto;
        n_retx    = r_retx;
        w_give_up = 1'b0;
        case (i_op)
            rtt_est_pkg::OP_INIT: begin
                n_srtt   = '0;
                n_rttvar = '0;
                n_rto    = {4'd0, i_cfg.min_rto};
            end
            rtt_est_pkg::OP_NEW_PKT: begin
                n_retx = '0;
            end
            rtt_est_pkg::OP_MEASURE: begin
                n_srtt   = w_srtt_meas;
                n_rttvar = w_rttvar_meas;
                n_rto    = w_rto_meas;
            end
            rtt_est_pkg::OP_TIMEOUT: begin
                n_rto     = w_rto_clamp;
                n_retx    = w_retx_inc;
                w_give_up = (w_retx_inc > i_cfg.max_retx);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt   <= '0;
            r_rttvar <= '0;
            r_rto    <= {4'd0, rtt_est_pkg::MIN_RTO_RESET};
            r_retx   <= '0;
        end else if (i_advance) begin
            r_srtt   <= n_srtt;
            r_rttvar <= n_rttvar;
            r_rto    <= n_rto;
            r_retx   <= n_retx;
        end
    end

    assign o_result.rto     = n_rto;
    assign o_result.give_up = w_give_up;

endmodule

// ===== hw/rtl/rtt_estimator_rto_backoff_top.sv =====
// Top level of the RTT estimator with exponential timeout backoff.
// Each transaction on the input channel is one event (init, new packet, measured
// sample or timeout) and produces exactly one result transaction carrying the
// retransmission timeout in microseconds and the give-up flag. An event is taken
// into an input register, processed by the event datapath while the estimator
// state is updated, and the result is held in an output register. One event per
// cycle is sustained; only a stalled output channel slows the block down.
// Configuration writes take effect on the next event and should be made while
// no event is in flight.
module rtt_estimator_rto_backoff_top #(
    parameter int unsigned SAMPLE_BITS = rtt_est_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rtt_est_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rtt_est_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rtt_est_pkg::OP_W-1:0]        i_operation,
    input  logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] i_sample_us,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rtt_est_pkg::RTO_W-1:0]       o_rto_us,
    output logic                                o_give_up
);

    rtt_est_pkg::t_cfg    w_cfg;
    rtt_est_pkg::t_result w_result;

    logic                           r_in_valid;
    logic [rtt_est_pkg::OP_W-1:0]   r_op;
    logic [SAMPLE_BITS-1:0]         r_sample;
    logic                           r_out_valid;
    rtt_est_pkg::t_result           r_result;
    logic                           w_advance;
    logic                           w_in_take;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    rtt_est_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    rtt_est_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_op      (r_op),
        .i_sample  (r_sample),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op     <= i_operation;
            r_sample <= i_sample_us[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rto_us    = r_result.rto;
    assign o_give_up   = r_result.give_up;

    a_give_up_on_timeout_only: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_result.give_up) |-> (r_op == rtt_est_pkg::OP_TIMEOUT)
    ) else $error("give-up raised for an event other than a timeout");

    a_init_sets_min: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_op == rtt_est_pkg::OP_INIT)
            |=> (o_rto_us == {4'd0, $past(w_cfg.min_rto)}) && !o_give_up
    ) else $error("init did not set the timeout to the lower limit");

    a_result_from_event: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance)
    ) else $error("result appeared without an event being processed");

    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_advance
    ) else $error("pending result overwritten by a new event");

endmodule

// ===== tb/rtt_estimator_rto_backoff_chk.sv =====
// Checker for the RTT estimator: watches both channels, predicts each result and compares.
module rtt_estimator_rto_backoff_chk #(
    parameter int unsigned SAMPLE_BITS = rtt_est_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rtt_est_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rtt_est_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [rtt_est_pkg::OP_W-1:0]         i_operation,
    input  logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] i_sample_us,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [rtt_est_pkg::RTO_W-1:0]        i_rto_us,
    input  logic                                 i_give_up,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SAMPLE_MASK = (64'd1 << SAMPLE_BITS) - 64'd1;

    rtt_est_pkg::t_cfg                  window;
    logic [rtt_est_pkg::SRTT_W-1:0]     srtt_x8;
    logic [rtt_est_pkg::RTTVAR_W-1:0]   rttvar_x4;
    logic [rtt_est_pkg::RTO_W-1:0]      rto_now;
    logic [rtt_est_pkg::CNT_W-1:0]      retx_cnt;
    rtt_est_pkg::t_result               rto_queue[$];
    int                                 fails = 0;

    function automatic logic [rtt_est_pkg::RTO_W-1:0] clamp_to_window(input logic [63:0] v);
        if (v < {32'd0, window.min_rto}) begin
            return rtt_est_pkg::RTO_W'(window.min_rto);
        end
        if (v > {32'd0, window.max_rto}) begin
            return rtt_est_pkg::RTO_W'(window.max_rto);
        end
        return v[rtt_est_pkg::RTO_W-1:0];
    endfunction

    function automatic rtt_est_pkg::t_result predict_event(
        input logic [rtt_est_pkg::OP_W-1:0]         op,
        input logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] sample
    );
        rtt_est_pkg::t_result res;
        logic [63:0]          smp;
        logic [63:0]          prev_avg;
        logic [63:0]          abs_err;
        logic [63:0]          srtt_w;
        logic [63:0]          var_w;
        res.give_up = 1'b0;
        case (op)
            rtt_est_pkg::OP_INIT: begin
                srtt_x8   = '0;
                rttvar_x4 = '0;
                rto_now   = clamp_to_window(64'd0);
            end
            rtt_est_pkg::OP_NEW_PKT: begin
                retx_cnt = '0;
            end
            rtt_est_pkg::OP_MEASURE: begin
                smp      = {32'd0, sample} & SAMPLE_MASK;
                srtt_w   = {28'd0, srtt_x8};
                prev_avg = srtt_w >> 3;
                abs_err  = (smp >= prev_avg) ? smp - prev_avg : prev_avg - smp;
                srtt_w   = srtt_w - prev_avg + smp;
                srtt_x8  = srtt_w[rtt_est_pkg::SRTT_W-1:0];
                var_w    = {29'd0, rttvar_x4};
                var_w    = var_w - (var_w >> 2) + abs_err;
                rttvar_x4 = var_w[rtt_est_pkg::RTTVAR_W-1:0];
                srtt_w   = {28'd0, srtt_x8};
                var_w    = {29'd0, rttvar_x4};
                srtt_w   = (srtt_w >> 3) + var_w;
                rto_now  = srtt_w[rtt_est_pkg::RTO_W-1:0];
            end
            rtt_est_pkg::OP_TIMEOUT: begin
                srtt_w  = {28'd0, rto_now};
                rto_now = clamp_to_window(srtt_w << 1);
                if (retx_cnt != rtt_est_pkg::CNT_SAT) begin
                    retx_cnt = retx_cnt + 1'b1;
                end
                res.give_up = (retx_cnt > window.max_retx);
            end
            default: begin
            end
        endcase
        res.rto = rto_now;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin : track
        rtt_est_pkg::t_result got;
        rtt_est_pkg::t_result want;
        if (!i_rst_n) begin
            window.min_rto  = rtt_est_pkg::MIN_RTO_RESET;
            window.max_rto  = rtt_est_pkg::MAX_RTO_RESET;
            window.max_retx = rtt_est_pkg::MAX_RETX_RESET;
            srtt_x8   = '0;
            rttvar_x4 = '0;
            rto_now   = rtt_est_pkg::RTO_W'(rtt_est_pkg::MIN_RTO_RESET);
            retx_cnt  = '0;
            rto_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rtt_est_pkg::REG_MIN_RTO:  window.min_rto  = i_cfg_wdata;
                    rtt_est_pkg::REG_MAX_RTO:  window.max_rto  = i_cfg_wdata;
                    rtt_est_pkg::REG_MAX_RETX: begin
                        window.max_retx = i_cfg_wdata[rtt_est_pkg::CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.rto     = i_rto_us;
                got.give_up = i_give_up;
                if (rto_queue.size() == 0) begin
                    report_mismatch("result transaction with none outstanding",
                                    {28'd0, got.rto}, 64'd0);
                end else begin
                    want = rto_queue.pop_front();
                    if (got.rto !== want.rto) begin
                        report_mismatch("rto_us", {28'd0, got.rto}, {28'd0, want.rto});
                    end
                    if (got.give_up !== want.give_up) begin
                        report_mismatch("give_up", {63'd0, got.give_up}, {63'd0, want.give_up});
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                rto_queue.push_back(predict_event(i_operation, i_sample_us));
            end
        end
        o_pending    <= rto_queue.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/rtt_estimator_rto_backoff_top_tb.sv =====
// Testbench top for the RTT estimator: clock, reset, stimulus, flow control and verdict.
module rtt_estimator_rto_backoff_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned PHASE_ITEMS   = 120;
    localparam logic [rtt_est_pkg::OP_W-1:0] ALL_OPS[4] = '{
        rtt_est_pkg::OP_INIT, rtt_est_pkg::OP_NEW_PKT,
        rtt_est_pkg::OP_MEASURE, rtt_est_pkg::OP_TIMEOUT
    };

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [rtt_est_pkg::CFG_IDX_W-1:0]    i_cfg_idx   = '0;
    logic [rtt_est_pkg::CFG_W-1:0]        i_cfg_wdata = '0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_ready;
    logic [rtt_est_pkg::OP_W-1:0]         i_operation = rtt_est_pkg::OP_INIT;
    logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] i_sample_us = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic [rtt_est_pkg::RTO_W-1:0]        o_rto_us;
    logic                                 o_give_up;

    int          fail_count;
    int          pending;
    bit          hold_off_req = 1'b0;
    bit          no_idle      = 1'b0;
    int unsigned cycle_count  = 0;

    rtt_estimator_rto_backoff_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_sample_us (i_sample_us),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rto_us    (o_rto_us),
        .o_give_up   (o_give_up)
    );

    rtt_estimator_rto_backoff_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_sample_us  (i_sample_us),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_rto_us     (o_rto_us),
        .i_give_up    (o_give_up),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return $urandom_range(1, 3);
        end
        if (r < 92) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [rtt_est_pkg::CFG_W-1:0] pick_clamp();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end
        if (r < 30) begin
            return '1;
        end
        if (r < 65) begin
            return $urandom_range(100000, 5000000);
        end
        return $urandom;
    endfunction

    function automatic logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] pick_base();
        int unsigned r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            return $urandom_range(50, 2000);
        end
        if (r == 1) begin
            return $urandom_range(10000, 2000000);
        end
        return $urandom;
    endfunction

    function automatic logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] pick_sample(
        input logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] base
    );
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 10) begin
            return '1;
        end
        if (r < 30) begin
            return $urandom;
        end
        return base + $urandom_range(0, base / 2) - base / 4;
    endfunction

    // The receiver alternates runs of readiness with stalls, unless a hold-off is requested; no_idle keeps it ready.
    initial begin : rx_side
        int unsigned run_left;
        bit          run_ready;
        run_left  = 0;
        run_ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    run_left  = run_ready ? $urandom_range(1, 30) : idle_length();
                end
                i_out_ready <= no_idle || run_ready;
                run_left--;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_event(input logic [rtt_est_pkg::OP_W-1:0] op,
                              input logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] smp);
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_sample_us <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        gap = (no_idle || $urandom_range(0, 99) < 40) ? 0 : idle_length();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [rtt_est_pkg::CFG_W-1:0] min_val,
                                input logic [rtt_est_pkg::CFG_W-1:0] max_val,
                                input logic [rtt_est_pkg::CNT_W-1:0] retx_val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= rtt_est_pkg::REG_MIN_RTO;
        i_cfg_wdata <= min_val;
        @(posedge i_clk);
        i_cfg_idx   <= rtt_est_pkg::REG_MAX_RTO;
        i_cfg_wdata <= max_val;
        @(posedge i_clk);
        i_cfg_idx   <= rtt_est_pkg::REG_MAX_RETX;
        i_cfg_wdata <= {{(rtt_est_pkg::CFG_W-rtt_est_pkg::CNT_W){1'b0}}, retx_val};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly packet lifecycles: a new packet, a run of timeouts, then one or more samples.
    task automatic run_phase(input int unsigned n_items,
                             input logic [rtt_est_pkg::CNT_W-1:0] retx_limit);
        int unsigned sent;
        int unsigned r;
        int unsigned lim;
        int unsigned k;
        int unsigned m;
        logic [rtt_est_pkg::SAMPLE_W_MAX-1:0] base;
        sent = 0;
        base = pick_base();
        lim  = (retx_limit > 10) ? 10 : retx_limit;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_event(rtt_est_pkg::OP_INIT, $urandom);
                sent++;
            end else if (r < 15) begin
                send_event(ALL_OPS[$urandom_range(0, 3)], pick_sample(base));
                sent++;
            end else begin
                send_event(rtt_est_pkg::OP_NEW_PKT, $urandom);
                k = $urandom_range(0, lim + 2);
                m = $urandom_range(1, 3);
                repeat (k) send_event(rtt_est_pkg::OP_TIMEOUT, $urandom);
                repeat (m) send_event(rtt_est_pkg::OP_MEASURE, pick_sample(base));
                sent += 1 + k + m;
            end
        end
    endtask

    initial begin : stimulus
        logic [rtt_est_pkg::CFG_W-1:0] min_val;
        logic [rtt_est_pkg::CFG_W-1:0] max_val;
        logic [rtt_est_pkg::CNT_W-1:0] retx_val;
        int unsigned                   r;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_INIT, 32'hFFFF_FFFF);
        send_event(rtt_est_pkg::OP_MEASURE, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_MEASURE, 32'hFFFF_FFFF);
        send_event(rtt_est_pkg::OP_MEASURE, 32'hFFFF_FFFF);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h1234_5678);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_NEW_PKT, 32'hFFFF_FFFF);
        send_event(rtt_est_pkg::OP_MEASURE, 32'h0000_0001);
        send_event(rtt_est_pkg::OP_MEASURE, 32'h5555_5555);
        send_event(rtt_est_pkg::OP_MEASURE, 32'hAAAA_AAAA);
        send_event(rtt_est_pkg::OP_INIT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        wait_idle();

        program_regs('0, '1, '0);
        send_event(rtt_est_pkg::OP_INIT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_MEASURE, 32'hFFFF_FFFF);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        wait_idle();

        // Lower clamp above the upper one: the lower clamp must win.
        program_regs('1, '0, rtt_est_pkg::CNT_SAT);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_INIT, 32'h0000_0000);
        send_event(rtt_est_pkg::OP_TIMEOUT, 32'h0000_0000);
        wait_idle();

        // Drive the retransmit count into saturation, then lower the limit beneath it.
        program_regs(rtt_est_pkg::MIN_RTO_RESET, rtt_est_pkg::MAX_RTO_RESET,
                     rtt_est_pkg::CNT_SAT);
        send_event(rtt_est_pkg::OP_NEW_PKT, $urandom);
        repeat (260) send_event(rtt_est_pkg::OP_TIMEOUT, $urandom);
        wait_idle();
        program_regs(rtt_est_pkg::MIN_RTO_RESET, rtt_est_pkg::MAX_RTO_RESET,
                     rtt_est_pkg::CNT_SAT - 1'b1);
        send_event(rtt_est_pkg::OP_TIMEOUT, $urandom);
        send_event(rtt_est_pkg::OP_NEW_PKT, $urandom);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                min_val  = rtt_est_pkg::MIN_RTO_RESET;
                max_val  = rtt_est_pkg::MAX_RTO_RESET;
                retx_val = rtt_est_pkg::MAX_RETX_RESET;
            end else if (p == 1) begin
                min_val  = '0;
                max_val  = '1;
                retx_val = '0;
            end else if (p == 2) begin
                min_val  = '1;
                max_val  = '0;
                retx_val = rtt_est_pkg::CNT_SAT;
            end else begin
                min_val  = pick_clamp();
                max_val  = pick_clamp();
                r        = $urandom_range(0, 99);
                retx_val = (r < 10) ? '0 : (r < 20) ? rtt_est_pkg::CNT_SAT
                                                    : rtt_est_pkg::CNT_W'($urandom_range(1, 8));
            end
            program_regs(min_val, max_val, retx_val);
            if (p == 3) begin
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
            end
            if (p == 6) begin
                no_idle = 1'b1;
            end
            run_phase(PHASE_ITEMS / 2, retx_val);
            if (p == 5) begin
                wait_idle();
            end
            run_phase(PHASE_ITEMS / 2, retx_val);
            no_idle = 1'b0;
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rtt_est_pkg.sv
hw/rtl/rtt_est_cfg.sv
hw/rtl/rtt_est_core.sv
hw/rtl/rtt_estimator_rto_backoff_top.sv
tb/rtt_estimator_rto_backoff_chk.sv
tb/rtt_estimator_rto_backoff_top_tb.sv
